// File: rtl/core/b64_pkg.sv
// Shared types, constants and symbol mapping functions for the base64url codec.
`default_nettype none

package b64_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;  // 'z'
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;  // '0'
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;  // '9'
  localparam logic [7:0] CH_DASH    = 8'h2D;  // '-'
  localparam logic [7:0] CH_USCORE  = 8'h5F;  // '_'

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic       stopped;
  } res_t;

  // One queue entry holds every result that one request causes.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } q_entry_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sym_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    case (v) inside
      [6'd0 : 6'd25]:  c = CH_UPPER_A + w;
      [6'd26 : 6'd51]: c = CH_LOWER_A + w - 8'd26;
      [6'd52 : 6'd61]: c = CH_DIGIT_0 + w - 8'd52;
      6'd62:           c = CH_DASH;
      default:         c = CH_USCORE;
    endcase
    return c;
  endfunction

  function automatic sym_t dec_sym(input logic [7:0] ch);
    sym_t s;
    s.ok  = 1'b1;
    s.val = 6'd0;
    case (ch) inside
      [CH_UPPER_A : CH_UPPER_Z]: s.val = 6'(ch - CH_UPPER_A);
      [CH_LOWER_A : CH_LOWER_Z]: s.val = 6'(ch - CH_LOWER_A + 8'd26);
      [CH_DIGIT_0 : CH_DIGIT_9]: s.val = 6'(ch - CH_DIGIT_0 + 8'd52);
      CH_DASH:                   s.val = 6'd62;
      CH_USCORE:                 s.val = 6'd63;
      default:                   s.ok  = 1'b0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/b64_channels.sv
// Valid/ready channel interfaces for input, output and mode write requests.
`default_nettype none

interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source(output valid, in_byte, in_last, input ready);
  modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;
  logic       stopped;
  modport source(output valid, out_byte, out_valid, out_last, stopped, input ready);
  modport sink(input valid, out_byte, out_valid, out_last, stopped, output ready);
endinterface

interface b64_cfg_if;
  logic valid;
  logic ready;
  logic mode;
  modport source(output valid, mode, input ready);
  modport sink(input valid, mode, output ready);
endinterface

`default_nettype wire

// File: rtl/core/b64_front.sv
// Front end: accepts requests, runs the bit accumulator and builds queue entries.
`default_nettype none

module b64_front (
  input  wire                  clk,
  input  wire                  rst,
  b64_in_if.sink               din,
  b64_cfg_if.sink              cfg,
  input  wire                  q_full,
  output logic                 q_push,
  output b64_pkg::q_entry_t    q_data
);
  import b64_pkg::*;

  logic        mode;
  logic [15:0] acc;
  logic [3:0]  pend;
  logic        halted;

  logic [15:0] acc_next;
  logic [3:0]  pend_next;
  logic        halted_next;

  logic        take;

  logic [15:0] e_acc;
  logic [3:0]  e_p;
  logic [1:0]  e_n;
  logic [5:0]  e_s0;
  logic [5:0]  e_s1;

  sym_t        d_sym;
  logic [15:0] d_acc;
  logic [3:0]  d_p;
  logic        d_have;
  logic [7:0]  d_byte;

  assign cfg.ready = 1'b1;
  assign din.ready = !q_full;
  assign take      = din.valid && !q_full;

  // Encode: shift in 8 bits, peel off up to two symbols, flush leftovers on last.
  always_comb begin
    e_acc = {acc[7:0], din.in_byte};
    e_p   = pend + 4'd8;
    e_n   = 2'd0;
    e_s0  = 6'd0;
    e_s1  = 6'd0;
    if (e_p >= 4'd6) begin
      e_s0 = 6'(e_acc >> (e_p - 4'd6));
      e_p  = e_p - 4'd6;
      e_n  = 2'd1;
    end
    if (e_p >= 4'd6) begin
      e_s1 = 6'(e_acc >> (e_p - 4'd6));
      e_p  = e_p - 4'd6;
      e_n  = 2'd2;
    end
    if (din.in_last && e_p != 4'd0 && e_p < 4'd6 && e_n < 2'd2) begin
      if (e_n == 2'd0) begin
        e_s0 = 6'(e_acc << (4'd6 - e_p));
      end else begin
        e_s1 = 6'(e_acc << (4'd6 - e_p));
      end
      e_n = e_n + 2'd1;
      e_p = 4'd0;
    end
  end

  // Decode: map the character to 6 bits, emit a byte once 8 bits are pending.
  always_comb begin
    d_sym  = dec_sym(din.in_byte);
    d_acc  = {acc[9:0], d_sym.val};
    d_p    = pend + 4'd6;
    d_have = 1'b0;
    d_byte = 8'd0;
    if (d_p >= 4'd8) begin
      d_byte = 8'(d_acc >> (d_p - 4'd8));
      d_p    = d_p - 4'd8;
      d_have = 1'b1;
    end
  end

  always_comb begin
    acc_next    = acc;
    pend_next   = pend;
    halted_next = halted;
    q_push      = 1'b0;
    q_data      = '0;
    if (mode == MODE_ENCODE) begin
      acc_next  = e_acc;
      pend_next = e_p;
      q_push    = take && (e_n != 2'd0);
      q_data.two          = (e_n == 2'd2);
      q_data.r0.out_byte  = enc_char(e_s0);
      q_data.r0.out_valid = 1'b1;
      q_data.r0.out_last  = din.in_last && (e_n == 2'd1);
      q_data.r0.stopped   = 1'b0;
      q_data.r1.out_byte  = enc_char(e_s1);
      q_data.r1.out_valid = 1'b1;
      q_data.r1.out_last  = din.in_last;
      q_data.r1.stopped   = 1'b0;
    end else begin
      if (!halted) begin
        if (!d_sym.ok) begin
          halted_next = 1'b1;
        end else begin
          acc_next  = d_acc;
          pend_next = d_p;
        end
      end
      q_push = take && ((!halted && d_sym.ok && d_have) || din.in_last);
      if (!halted && d_sym.ok && d_have) begin
        q_data.r0.out_byte  = d_byte;
        q_data.r0.out_valid = 1'b1;
        q_data.r0.out_last  = din.in_last;
      end else begin
        q_data.r0.out_byte  = 8'd0;
        q_data.r0.out_valid = 1'b0;
        q_data.r0.out_last  = 1'b1;
      end
      q_data.r0.stopped = halted_next;
    end
    // A string end starts the next string clean.
    if (din.in_last) begin
      acc_next    = '0;
      pend_next   = '0;
      halted_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_ENCODE;
      acc    <= '0;
      pend   <= '0;
      halted <= 1'b0;
    end else if (cfg.valid) begin
      mode   <= cfg.mode;
      acc    <= '0;
      pend   <= '0;
      halted <= 1'b0;
    end else if (take) begin
      acc    <= acc_next;
      pend   <= pend_next;
      halted <= halted_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/b64_queue.sv
// Short register queue between the front end and the output stage.
`default_nettype none

module b64_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  b64_pkg::q_entry_t    push_data,
  input  wire                  pop,
  output logic                 full,
  output logic                 empty,
  output b64_pkg::q_entry_t    head
);
  import b64_pkg::*;

  q_entry_t            slots [QDEPTH];
  logic [QAW-1:0]      wr_ptr;
  logic [QAW-1:0]      rd_ptr;
  logic [QAW:0]        count;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/b64_back.sv
// Back end: drains queue to output reg, one result per cycle unless stalled.
`default_nettype none

module b64_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  q_empty,
  input  b64_pkg::q_entry_t    q_head,
  output logic                 q_pop,
  b64_out_if.source            dout
);
  import b64_pkg::*;

  logic  o_valid;
  res_t  o_data;
  logic  sel;
  logic  load;
  res_t  pick;

  assign load  = !q_empty && (!o_valid || dout.ready);
  assign pick  = sel ? q_head.r1 : q_head.r0;
  assign q_pop = load && (sel || !q_head.two);

  assign dout.valid     = o_valid;
  assign dout.out_byte  = o_data.out_byte;
  assign dout.out_valid = o_data.out_valid;
  assign dout.out_last  = o_data.out_last;
  assign dout.stopped   = o_data.stopped;

  always_ff @(posedge clk) begin
    if (load) begin
      o_data <= pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      sel     <= 1'b0;
    end else begin
      if (load) begin
        o_valid <= 1'b1;
      end else if (dout.ready) begin
        o_valid <= 1'b0;
      end
      // Advance to the second result of a two-symbol entry, else restart.
      if (load) begin
        sel <= !q_pop;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/base64url_stream_codec.sv
// Top level of the streaming base64url encoder/decoder.
//
//   channel  dir  handshake         payload
//   din      in   valid / ready     in_byte[7:0], in_last
//   dout     out  valid / ready     out_byte[7:0], out_valid, out_last, stopped
//   cfg      in   valid / ready     mode (0 encode, 1 decode), ready always high
//
// One request per cycle when it yields at most one result and dout is not stalled;
// an encode request that yields two characters is drained one character at a time
// through the single output register. With an empty queue and a free dout, a result
// passes through a queue slot and then the output register before it shows on dout.
// Synchronous reset clears mode, accumulator, queue and output register.
// A stalled dout fills the two-entry queue, then din.ready drops.
`default_nettype none

module base64url_stream_codec (
  input  wire        clk,
  input  wire        rst,
  b64_in_if.sink     din,
  b64_out_if.source  dout,
  b64_cfg_if.sink    cfg
);
  import b64_pkg::*;

  logic     q_push;
  q_entry_t q_data;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  q_entry_t q_head;

  b64_front u_front (
    .clk    (clk),
    .rst    (rst),
    .din    (din),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  b64_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  b64_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .dout    (dout)
  );

endmodule

`default_nettype wire

// File: rtl/core/b64_checker.sv
// Port-level assertions for the base64url codec, bound to the top level.
`default_nettype none

module b64_checker (
  input wire       clk,
  input wire       rst,
  input wire       dout_valid,
  input wire       dout_ready,
  input wire [7:0] dout_byte,
  input wire       dout_out_valid,
  input wire       dout_out_last,
  input wire       dout_stopped
);

  // Hold a stalled result.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    dout_valid && !dout_ready |=> dout_valid)
    else $error("result dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !dout_valid)
    else $error("result present right after reset");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    dout_valid && !dout_out_valid |-> dout_out_last && (dout_byte == 8'd0))
    else $error("empty result is not a clean end marker");

  a_stopped_form: assert property (@(posedge clk) disable iff (rst)
    dout_valid && dout_stopped |-> !dout_out_valid && dout_out_last)
    else $error("halted decode produced data or a non-final result");

endmodule

bind base64url_stream_codec b64_checker u_b64_checker (
  .clk            (clk),
  .rst            (rst),
  .dout_valid     (dout.valid),
  .dout_ready     (dout.ready),
  .dout_byte      (dout.out_byte),
  .dout_out_valid (dout.out_valid),
  .dout_out_last  (dout.out_last),
  .dout_stopped   (dout.stopped)
);

`default_nettype wire
